>>> rtl/aacdrc_pkg.sv
// Shared types, codes and constants for the AAC DRC band gain block.
// Holds the payload structs, the register codes and the 2^(k/24) mantissa table.
// No dependencies.
package aacdrc_pkg;

  localparam int POS_W   = 10;  // frame position width
  localparam int BOUND_W = 11;  // band bound width, 4*(top+1) up to 1024
  localparam int MANT_W  = 17;  // Q16 mantissa
  localparam int SHIFT_W = 5;   // exponent plus bias
  localparam int PROD_W  = 49;  // 32-bit sample times 17-bit mantissa, signed

  localparam int MANT_STEPS  = 24;   // steps per octave
  localparam int M_BIAS      = 768;  // 24*32, keeps the step count positive
  localparam int EXP_OFFSET  = 16;   // stored shift is exponent plus this
  localparam int DIV3_RECIP  = 171;  // floor(v/3) = (v*171) >> 9 for v < 512
  localparam int DIV3_SHIFT  = 9;
  localparam int ROUND_Q7    = 64;   // half of 128

  localparam logic [MANT_W-1:0]  UNITY_MANT  = 17'd65536;
  localparam logic [SHIFT_W-1:0] UNITY_SHIFT = 5'd16;

  // Item opcodes.
  localparam logic OP_DESC   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CUT_AMOUNT    = 2'd0,
    CFG_BOOST_AMOUNT  = 2'd1,
    CFG_BAND_COUNT    = 2'd2,
    CFG_PROGRAM_LEVEL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              op;
    logic [3:0]        band_index;
    logic [7:0]        top_group;
    logic              compress;
    logic [6:0]        control;
    logic signed [31:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [31:0] scaled_sample;
    logic [POS_W-1:0]   position;
    logic               frame_end;
  } result_t;

  typedef struct packed {
    logic [7:0] cut_amount;
    logic [7:0] boost_amount;
    logic [4:0] band_count;
    logic [6:0] program_level;
  } drc_cfg_t;

  typedef struct packed {
    logic [MANT_W-1:0]  mant;
    logic [SHIFT_W-1:0] shift;
  } gain_t;

  // A sample on its way to the multiplier, with the gain already chosen.
  typedef struct packed {
    logic signed [31:0] x;
    gain_t              gain;
    logic [POS_W-1:0]   position;
    logic               frame_end;
  } tap_t;

  // round(65536 * 2^(k/24)).
  function automatic logic [MANT_W-1:0] mant_lookup(input logic [4:0] k);
    logic [MANT_W-1:0] m;
    case (k)
      5'd0:  m = 17'd65536;
      5'd1:  m = 17'd67456;
      5'd2:  m = 17'd69433;
      5'd3:  m = 17'd71468;
      5'd4:  m = 17'd73562;
      5'd5:  m = 17'd75717;
      5'd6:  m = 17'd77936;
      5'd7:  m = 17'd80220;
      5'd8:  m = 17'd82570;
      5'd9:  m = 17'd84990;
      5'd10: m = 17'd87480;
      5'd11: m = 17'd90043;
      5'd12: m = 17'd92682;
      5'd13: m = 17'd95398;
      5'd14: m = 17'd98193;
      5'd15: m = 17'd101070;
      5'd16: m = 17'd104032;
      5'd17: m = 17'd107080;
      5'd18: m = 17'd110218;
      5'd19: m = 17'd113448;
      5'd20: m = 17'd116772;
      5'd21: m = 17'd120194;
      5'd22: m = 17'd123715;
      5'd23: m = 17'd127341;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/aacdrc_gain_calc.sv
// Band gain computation: control value and registers to Q16 mantissa and shift.
// Combinational; depends on aacdrc_pkg.
module aacdrc_gain_calc #(
  parameter int REF_LEVEL = 80
) (
  input  aacdrc_pkg::drc_cfg_t cfg,
  input  logic                 compress,
  input  logic [6:0]           control,
  output aacdrc_pkg::gain_t    gain
);
  import aacdrc_pkg::*;

  logic [7:0]  amount;
  logic [15:0] scaled;
  logic [8:0]  r;
  logic [10:0] base;
  logic [10:0] m;
  logic [15:0] div_prod;
  logic [5:0]  q;
  logic [10:0] rem;

  always_comb begin
    amount   = compress ? cfg.cut_amount : cfg.boost_amount;
    scaled   = 16'(amount) * 16'(control) + 16'(ROUND_Q7);
    r        = 9'(scaled >> 7);
    // Step count biased by 24*32 so that it stays positive.
    base     = 11'(M_BIAS - REF_LEVEL) + 11'(cfg.program_level);
    m        = compress ? (base - 11'(r)) : (base + 11'(r));
    // m / 24 as (m / 8) / 3.
    div_prod = 16'(m[10:3]) * 16'(DIV3_RECIP);
    q        = 6'(div_prod >> DIV3_SHIFT);
    rem      = m - 11'(q) * 11'(MANT_STEPS);
    gain.mant  = mant_lookup(rem[4:0]);
    gain.shift = 5'(q - 6'(EXP_OFFSET));
  end

endmodule

>>> rtl/aacdrc_band_stage.sv
// Front end: input register, band table, frame position and gain selection.
// Depends on aacdrc_pkg and aacdrc_gain_calc.
module aacdrc_band_stage #(
  parameter int MAX_BANDS   = 16,
  parameter int FRAME_LEN   = 1024,
  parameter int REF_LEVEL   = 80,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  aacdrc_pkg::drc_cfg_t cfg,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  aacdrc_pkg::item_t    item,
  output logic                 tap_valid,
  input  logic                 tap_ready,
  output aacdrc_pkg::tap_t     tap
);
  import aacdrc_pkg::*;

  localparam int PAD = 32 - SAMPLE_BITS;
  localparam int RST_M = M_BIAS - REF_LEVEL;
  localparam logic [MANT_W-1:0]  RST_MANT  = mant_lookup(5'(RST_M % MANT_STEPS));
  localparam logic [SHIFT_W-1:0] RST_SHIFT = 5'(RST_M / MANT_STEPS - EXP_OFFSET);

  logic               valid1;
  item_t              item1;
  gain_t              gains [MAX_BANDS];
  logic [BOUND_W-1:0] band_bound [MAX_BANDS];
  logic [POS_W-1:0]   frame_pos;
  logic [POS_W-1:0]   frame_pos_next;

  gain_t              new_gain;
  gain_t              sel_gain;
  tap_t               tap_next;
  logic               is_desc;
  logic               ready2;
  logic               s1_done;
  logic               table_wr;
  logic [4:0]         count_eff;
  logic [BOUND_W-1:0] bound_b;
  logic [BOUND_W-1:0] pos_inc;
  logic signed [31:0] x_shl;
  logic signed [31:0] x_ext;

  aacdrc_gain_calc #(.REF_LEVEL(REF_LEVEL)) u_gain_calc (
    .cfg      (cfg),
    .compress (item1.compress),
    .control  (item1.control),
    .gain     (new_gain)
  );

  assign is_desc    = (item1.op == OP_DESC);
  assign ready2     = !tap_valid || tap_ready;
  assign s1_done    = valid1 && (is_desc || ready2);
  assign item_ready = !valid1 || s1_done;
  assign table_wr   = s1_done && is_desc && (5'(item1.band_index) < 5'(MAX_BANDS));

  // First band in use whose bound lies above the current position.
  always_comb begin
    count_eff = (cfg.band_count > 5'(MAX_BANDS)) ? 5'(MAX_BANDS) : cfg.band_count;
    sel_gain.mant  = UNITY_MANT;
    sel_gain.shift = UNITY_SHIFT;
    bound_b = '0;
    for (int b = MAX_BANDS - 1; b >= 0; b--) begin
      bound_b = (count_eff == 5'd1) ? BOUND_W'(FRAME_LEN) : band_bound[b];
      if ((5'(b) < count_eff) && (bound_b > BOUND_W'(frame_pos))) begin
        sel_gain = gains[b];
      end
    end
  end

  always_comb begin
    x_shl = item1.sample <<< PAD;
    x_ext = x_shl >>> PAD;
    pos_inc = BOUND_W'(frame_pos) + BOUND_W'(1);
    tap_next.x         = x_ext;
    tap_next.gain      = sel_gain;
    tap_next.position  = frame_pos;
    tap_next.frame_end = (BOUND_W'(frame_pos) >= BOUND_W'(FRAME_LEN - 1));
    if (is_desc) begin
      frame_pos_next = '0;
    end else if (pos_inc >= BOUND_W'(FRAME_LEN)) begin
      frame_pos_next = '0;
    end else begin
      frame_pos_next = pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (item_ready) begin
      valid1 <= item_valid;
    end
    if (item_valid && item_ready) begin
      item1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else if (ready2) begin
      tap_valid <= valid1 && !is_desc;
    end
    if (ready2 && valid1 && !is_desc) begin
      tap <= tap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
    end else if (s1_done) begin
      frame_pos <= frame_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < MAX_BANDS; b++) begin
        gains[b].mant  <= RST_MANT;
        gains[b].shift <= RST_SHIFT;
        band_bound[b]  <= (b == 0) ? BOUND_W'(1024) : '0;
      end
    end else if (table_wr) begin
      for (int b = 0; b < MAX_BANDS; b++) begin
        if (5'(item1.band_index) == 5'(b)) begin
          gains[b]      <= new_gain;
          band_bound[b] <= BOUND_W'({item1.top_group, 2'b00}) + BOUND_W'(4);
        end
      end
    end
  end

endmodule

>>> rtl/aacdrc_scale.sv
// Back end: gain multiply, round-to-nearest shift and saturation, output register.
// Depends on aacdrc_pkg.
module aacdrc_scale #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tap_valid,
  output logic                tap_ready,
  input  aacdrc_pkg::tap_t    tap,
  output logic                result_valid,
  input  logic                result_ready,
  output aacdrc_pkg::result_t result
);
  import aacdrc_pkg::*;

  localparam logic signed [PROD_W-1:0] SAT_HI =
    (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

  logic                      valid3;
  logic signed [PROD_W-1:0]  prod3;
  logic [SHIFT_W-1:0]        shift3;
  logic [POS_W-1:0]          pos3;
  logic                      end3;

  logic                      ready_out;
  logic signed [PROD_W:0]    full_prod;
  logic signed [PROD_W-1:0]  part;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [PROD_W-1:0]  sat;
  result_t                   result_next;

  assign ready_out = !result_valid || result_ready;
  assign tap_ready = !valid3 || ready_out;
  assign full_prod = (PROD_W + 1)'(tap.x) * (PROD_W + 1)'($signed({1'b0, tap.gain.mant}));

  // Shift right by 32 - shift with the half added first: shift by one less,
  // add one, then drop the last bit.
  always_comb begin
    part    = prod3 >>> (~shift3);
    rounded = (part + PROD_W'(1)) >>> 1;
    if (rounded > SAT_HI) begin
      sat = SAT_HI;
    end else if (rounded < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = rounded;
    end
    result_next.scaled_sample = 32'(sat);
    result_next.position      = pos3;
    result_next.frame_end     = end3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (tap_ready) begin
      valid3 <= tap_valid;
    end
    if (tap_valid && tap_ready) begin
      prod3  <= full_prod[PROD_W-1:0];
      shift3 <= tap.gain.shift;
      pos3   <= tap.position;
      end3   <= tap.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready_out) begin
      result_valid <= valid3;
    end
    if (valid3 && ready_out) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/aac_drc_band_gain.sv
// Top level of the AAC dynamic range control band gain block.
// Holds the configuration registers; depends on aacdrc_pkg, aacdrc_band_stage, aacdrc_scale.
//
//   Channel   Direction  Handshake                 Payload
//   item      in         item_valid / item_ready   item_t: descriptor or spectral sample
//   result    out        result_valid/result_ready result_t: scaled sample, position, end
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data (one register)
//
// One item can be accepted every cycle unless a stalled result has filled every
// stage. A sample passes the input register, the band select register and the
// multiplier register before the output register, which offers its result.
// A descriptor updates the band table in the cycle after its transfer and produces
// no result. Reset is synchronous and leaves the band table at its defined
// reset gains, with no item in flight.
// Each stage holds its item while the next is full, so a stalled result only
// stops input once every stage behind it is occupied.
module aac_drc_band_gain #(
  parameter int MAX_BANDS   = 16,
  parameter int FRAME_LEN   = 1024,
  parameter int REF_LEVEL   = 80,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  aacdrc_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output aacdrc_pkg::result_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import aacdrc_pkg::*;

  drc_cfg_t cfg;
  logic     tap_valid;
  logic     tap_ready;
  tap_t     tap;

  // Registers are taken in any cycle; software must write them only while idle, unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cut_amount    <= '0;
      cfg.boost_amount  <= '0;
      cfg.band_count    <= 5'd1;
      cfg.program_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CUT_AMOUNT:    cfg.cut_amount    <= cfg_data;
        CFG_BOOST_AMOUNT:  cfg.boost_amount  <= cfg_data;
        CFG_BAND_COUNT:    cfg.band_count    <= cfg_data[4:0];
        CFG_PROGRAM_LEVEL: cfg.program_level <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Band table, frame position and the choice of gain for each sample.
  aacdrc_band_stage #(
    .MAX_BANDS   (MAX_BANDS),
    .FRAME_LEN   (FRAME_LEN),
    .REF_LEVEL   (REF_LEVEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_band_stage (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .tap_valid  (tap_valid),
    .tap_ready  (tap_ready),
    .tap        (tap)
  );

  // Multiply by the chosen gain, round to nearest and saturate.
  aacdrc_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .tap_valid    (tap_valid),
    .tap_ready    (tap_ready),
    .tap          (tap),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  localparam logic signed [31:0] OUT_HI = 32'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [31:0] OUT_LO = -OUT_HI - 32'sd1;

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid && !tap_valid)
    else $error("pipeline not empty after reset");

  // A sample waiting between the stages keeps its gain and position.
  a_tap_hold: assert property (@(posedge clk) disable iff (rst)
    tap_valid && !tap_ready |=> tap_valid && $stable(tap))
    else $error("internal sample changed while stalled");

  // The frame end flag marks exactly the last position of a frame.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.frame_end == (result.position == 10'(FRAME_LEN - 1)))
    else $error("frame_end does not match position");

  // Saturation keeps every result inside the sample range.
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.scaled_sample <= OUT_HI && result.scaled_sample >= OUT_LO)
    else $error("result outside the saturation range");

endmodule

>>> test/aac_drc_band_gain_tb.sv
// Self-checking testbench for aac_drc_band_gain: band descriptors, spectral samples, registers.
// A scoreboard class predicts every scaled sample; plain tasks drive the item and register channels.
// Depends on aacdrc_pkg and the aac_drc_band_gain RTL.
module aac_drc_band_gain_tb;
  import aacdrc_pkg::*;

  localparam int MAX_BANDS   = 16;
  localparam int FRAME_LEN   = 1024;
  localparam int REF_LEVEL   = 80;
  // The sample path is four stages deep; a descriptor lands in the cycle after its transfer.
  localparam int SETTLE      = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam longint SAT_HI  = (longint'(1) <<< 31) - 1;
  localparam longint SAT_LO  = -(longint'(1) <<< 31);

  // Scoreboard: keeps its own copy of the registers and the band table, turns
  // each accepted item into the scaled sample it should produce, and checks
  // results in order against that store.
  class drc_gain_tracker;
    logic [7:0]  cut_amt;
    logic [7:0]  boost_amt;
    logic [4:0]  band_cnt;
    logic [6:0]  prog_lvl;
    logic [16:0] mant [MAX_BANDS];
    logic [4:0]  shift [MAX_BANDS];
    logic [10:0] bound [MAX_BANDS];
    logic [9:0]  frame_pos;
    logic [16:0] step_mant [24];
    result_t     scaled_due [$];
    int          errors;

    function new();
      step_mant = '{65536, 67456, 69433, 71468, 73562, 75717, 77936, 80220,
                    82570, 84990, 87480, 90043, 92682, 95398, 98193, 101070,
                    104032, 107080, 110218, 113448, 116772, 120194, 123715, 127341};
      errors = 0;
      clear();
    endfunction

    // State right after reset: every band holds a control-0 cut gain.
    function void clear();
      logic [16:0] m;
      logic [4:0]  s;
      cut_amt   = 8'd0;
      boost_amt = 8'd0;
      band_cnt  = 5'd1;
      prog_lvl  = 7'd0;
      derive_gain(1'b1, 7'd0, m, s);
      for (int b = 0; b < MAX_BANDS; b++) begin
        mant[b]  = m;
        shift[b] = s;
        bound[b] = 11'd0;
      end
      bound[0]  = 11'd1024;
      frame_pos = 10'd0;
      scaled_due.delete();
    endfunction

    // Gain in 1/24-octave steps, split into a table mantissa and a biased exponent.
    function void derive_gain(input logic cut, input logic [6:0] ctl,
                              output logic [16:0] m, output logic [4:0] s);
      int amount;
      int r;
      int n;
      int steps;
      amount = cut ? int'(cut_amt) : int'(boost_amt);
      r = (amount * int'(ctl) + 64) >>> 7;
      n = cut ? -r : r;
      n = n - (REF_LEVEL - int'(prog_lvl));
      steps = n + 24 * 32;
      m = step_mant[steps % 24];
      s = 5'(steps / 24 - 16);
    endfunction

    // Product rounded to nearest (ties upward) and saturated to 32 bits.
    function logic signed [31:0] scale_by_gain(input logic signed [31:0] x,
                                               input logic [16:0] m, input logic [4:0] s);
      int     rs;
      longint prod;
      longint y;
      rs   = 32 - int'(s);
      prod = longint'(x) * longint'(m);
      y    = (prod + (longint'(1) <<< (rs - 1))) >>> rs;
      if (y > SAT_HI) y = SAT_HI;
      if (y < SAT_LO) y = SAT_LO;
      return y[31:0];
    endfunction

    function void note_config(input cfg_reg_t idx, input logic [7:0] d);
      case (idx)
        CFG_CUT_AMOUNT:    cut_amt   = d;
        CFG_BOOST_AMOUNT:  boost_amt = d;
        CFG_BAND_COUNT:    band_cnt  = d[4:0];
        CFG_PROGRAM_LEVEL: prog_lvl  = d[6:0];
        default: ;
      endcase
    endfunction

    function void note_item(input item_t it);
      int          cnt;
      bit          hit;
      logic [10:0] lim;
      result_t     want;
      if (it.op == OP_DESC) begin
        bound[it.band_index] = 11'(4 * (int'(it.top_group) + 1));
        derive_gain(it.compress, it.control, mant[it.band_index], shift[it.band_index]);
        frame_pos = 10'd0;
      end else begin
        cnt = (band_cnt > MAX_BANDS) ? MAX_BANDS : int'(band_cnt);
        want.scaled_sample = it.sample;
        hit = 1'b0;
        for (int b = 0; b < cnt && !hit; b++) begin
          lim = (cnt == 1) ? 11'(FRAME_LEN) : bound[b];
          if (lim > frame_pos) begin
            want.scaled_sample = scale_by_gain(it.sample, mant[b], shift[b]);
            hit = 1'b1;
          end
        end
        want.position  = frame_pos;
        want.frame_end = (frame_pos == FRAME_LEN - 1);
        scaled_due.push_back(want);
        frame_pos = (frame_pos == FRAME_LEN - 1) ? 10'd0 : frame_pos + 10'd1;
      end
    endfunction

    function int pending();
      return scaled_due.size();
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", what);
    endtask

    task check_result(input result_t got);
      result_t want;
      if (scaled_due.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = scaled_due.pop_front();
      if (got.scaled_sample !== want.scaled_sample)
        report($sformatf("pos %0d scaled_sample got %h expected %h",
                         want.position, got.scaled_sample, want.scaled_sample));
      if (got.position !== want.position)
        report($sformatf("position got %0d expected %0d", got.position, want.position));
      if (got.frame_end !== want.frame_end)
        report($sformatf("pos %0d frame_end got %b expected %b",
                         want.position, got.frame_end, want.frame_end));
    endtask
  endclass

  // Every input starts at a known value; reset is high from time zero.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  item_t      item_in = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result_out;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;

  drc_gain_tracker gains;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  aac_drc_band_gain uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: check each transfer, then choose whether to stall the next cycle.
  // Handshake signals are sampled at the edge, so the values seen are the ones
  // that were in force just before it.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) gains.check_result(result_out);
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run that stops moving for too long is a hang.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Random filler for the fields an item type does not use, so every bit toggles.
  function automatic item_t random_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t desc_item(input logic [3:0] band, input logic [7:0] top,
                                      input logic cut, input logic [6:0] ctl);
    item_t it;
    it = random_item();
    it.op         = OP_DESC;
    it.band_index = band;
    it.top_group  = top;
    it.compress   = cut;
    it.control    = ctl;
    return it;
  endfunction

  function automatic item_t sample_item(input logic signed [31:0] x);
    item_t it;
    it = random_item();
    it.op     = OP_SAMPLE;
    it.sample = x;
    return it;
  endfunction

  // Samples lean toward the extremes so that saturation shows up often.
  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(512)) - 32'sd256;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [6:0] pick_control();
    case ($urandom_range(3))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [7:0] pick_amount();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd128;
      2: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Band counts include zero, one, the maximum, values past it and junk upper bits.
  function automatic logic [7:0] pick_count();
    case ($urandom_range(9))
      0: return {3'($urandom()), 5'd0};
      1: return 8'($urandom_range(17, 31));
      2: return 8'd1;
      3: return 8'd16;
      4: return 8'($urandom());
      default: return 8'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd127;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One item transfer. Valid is lowered only when a gap is taken, so a
  // back-to-back item never sees valid dropped and raised in one time step.
  task automatic send(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_in    <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    gains.note_item(it);
    items_sent++;
  endtask

  // Valid stays high across consecutive register writes; configure lowers it.
  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gains.note_config(idx, d);
  endtask

  // Registers change only with the block empty: the item side pauses until
  // every expected sample is back, then waits out any descriptor still landing.
  task automatic configure(input logic [7:0] cut, input logic [7:0] boost,
                           input logic [7:0] count, input logic [7:0] level);
    item_valid <= 1'b0;
    @(posedge clk);
    while (gains.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_CUT_AMOUNT, cut);
    write_reg(CFG_BOOST_AMOUNT, boost);
    write_reg(CFG_BAND_COUNT, count);
    write_reg(CFG_PROGRAM_LEVEL, level);
    cfg_valid <= 1'b0;
  endtask

  // A well-formed frame: descriptors for every band in use with rising tops,
  // then a run of samples that may cross bands and run past the last.
  task automatic band_frame(input int frame_len);
    int cnt;
    int used;
    int top;
    int last_top;
    int step;
    int reach;
    int len;
    cnt  = gains.band_cnt;
    used = (cnt == 0) ? 1 : ((cnt > MAX_BANDS) ? MAX_BANDS : cnt);
    top  = $urandom_range(3);
    last_top = top;
    for (int b = 0; b < used; b++) begin
      if (b == used - 1 && $urandom_range(7) == 0) top = 255;
      send(desc_item(4'(b), 8'(top), 1'($urandom_range(1)), pick_control()));
      last_top = top;
      step = $urandom_range(1, 4);
      top  = (top + step > 255) ? 255 : top + step;
    end
    reach = 4 * (last_top + 1) + 8;
    if (reach > 96) reach = 96;
    len = (frame_len > 0) ? frame_len : $urandom_range(1, reach);
    repeat (len) send(sample_item(pick_sample()));
  endtask

  // Noise: fully random items, descriptors in any order with any top.
  task automatic noise_burst();
    repeat ($urandom_range(2, 10)) send(random_item());
  endtask

  task automatic random_phase(input int target);
    int start;
    int frames;
    start = items_sent;
    while (items_sent - start < target) begin
      configure(pick_amount(), pick_amount(), pick_count(), pick_level());
      frames = $urandom_range(3, 8);
      while (frames > 0 && items_sent - start < target) begin
        if ($urandom_range(4) == 0) noise_burst();
        else band_frame(0);
        frames--;
      end
    end
  endtask

  initial begin
    gains = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 53;

    // Reset gains on the sample extremes.
    send(sample_item(32'sh7FFFFFFF));
    send(sample_item(32'sh80000000));

    // Two narrow bands: a full boost that saturates, then a full cut, then
    // positions past the last band that pass through untouched.
    configure(8'd128, 8'd128, 8'd2, 8'd127);
    send(desc_item(4'd0, 8'd0, 1'b0, 7'd127));
    send(desc_item(4'd1, 8'd1, 1'b1, 7'd127));
    send(sample_item(32'sh7FFFFFFF));
    send(sample_item(32'sh80000000));
    send(sample_item(32'sd1));
    send(sample_item(-32'sd1));
    send(sample_item(32'sh40000000));
    send(sample_item(-32'sd3));
    send(sample_item(32'sd7));
    send(sample_item(32'shC0000001));
    send(sample_item(32'sd123));
    send(sample_item(-32'sd123));

    // Band count zero (upper data bits set): every sample passes unchanged.
    configure(8'd255, 8'd0, 8'hE0, 8'h80);
    send(desc_item(4'd15, 8'd255, 1'b1, 7'd127));
    send(sample_item(32'sh7FFFFFFF));
    send(sample_item(32'sh80000000));

    // Count above the maximum with the largest amounts and level.
    configure(8'd255, 8'd255, 8'd31, 8'd127);
    send(desc_item(4'd0, 8'd255, 1'b0, 7'd127));
    send(sample_item(32'sd1));
    send(sample_item(-32'sd1));

    // Single band: band 0 covers the whole frame whatever its top says.
    configure(8'd0, 8'd0, 8'hE1, 8'd0);
    send(desc_item(4'd0, 8'd0, 1'b1, 7'd64));
    repeat (6) send(sample_item(pick_sample()));

    random_phase(60);
    send_idle_pct = 53;
    recv_idle_pct = 13;
    random_phase(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // One frame longer than FRAME_LEN, to reach the frame end and the wrap.
    configure(pick_amount(), pick_amount(), 8'd16, pick_level());
    band_frame(FRAME_LEN + 6);

    item_valid <= 1'b0;
    @(posedge clk);
    while (gains.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (gains.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
